[sv/tkst_pkg.sv]
// Shared types, constants and helpers for the top-k sum tracker.
package tkst_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CFG_W       = 9;
  localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int SUM_BITS    = 40;
  localparam int INDEX_BITS  = 8;
  localparam int DATA_BITS   = 32;

  localparam logic [1:0] CMD_HOLD = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_INS  = 2'd2;
  localparam logic [1:0] CMD_ROT  = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]      tag;
    logic [VALUE_BITS-1:0] value;
  } cell_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       take_right;
    logic       ge_self;
    logic       ge_left;
  } cell_ctl_t;

  // bit i is the OR of bits 0..i
  function automatic logic [MAX_ENTRIES-1:0] prefix_or(input logic [MAX_ENTRIES-1:0] v);
    logic [MAX_ENTRIES-1:0] r;
    r = v;
    for (int s = 1; s < MAX_ENTRIES; s = s * 2) begin
      r = r | (r << s);
    end
    return r;
  endfunction

endpackage

[sv/tkst_cell.sv]
// One cell of the sorted chain: holds a value and its entry tag.
module tkst_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tkst_pkg::IDX_W-1:0]    reset_tag,
  input  tkst_pkg::cell_ctl_t           ctl,
  input  tkst_pkg::cell_t               left,
  input  tkst_pkg::cell_t               right,
  input  tkst_pkg::cell_t               insert_item,
  output tkst_pkg::cell_t               data
);
  import tkst_pkg::*;

  cell_t data_next;

  always_comb begin
    unique case (ctl.cmd)
      CMD_DEL: data_next = ctl.take_right ? right : data;
      CMD_INS: data_next = ctl.ge_self ? data : (ctl.ge_left ? insert_item : left);
      CMD_ROT: data_next = right;
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data.tag   <= reset_tag;
      data.value <= '0;
    end else begin
      data <= data_next;
    end
  end

endmodule

[sv/tkst_accum.sv]
// Sum of the first k active cells as the chain rotates past the head.
module tkst_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          en,
  input  tkst_pkg::cell_t               head,
  input  logic [tkst_pkg::CMP_W-1:0]    neff,
  input  logic [tkst_pkg::CMP_W-1:0]    k,
  output logic [tkst_pkg::SUM_BITS-1:0] sum
);
  import tkst_pkg::*;

  logic [CMP_W-1:0] cnt;
  logic             active;
  logic             take;

  assign active = CMP_W'(head.tag) < neff;
  assign take   = active && (cnt < k);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sum <= '0;
      cnt <= '0;
    end else if (en) begin
      if (active) begin
        cnt <= cnt + CMP_W'(1);
      end
      if (take) begin
        sum <= sum + SUM_BITS'(head.value);
      end
    end
  end

endmodule

[sv/top_k_sum_tracker.sv]
// Top level: sorted cell chain with a rotating summation pass.
// A beat passes through removal, insertion and a full rotation of the chain before top_sum is registered.
// A new beat is taken only while idle, once the previous result has been loaded for output.
// An in-range update takes a removal step and an insertion step before the rotation.
// Reset: cells hold zero with tags 0..MAX_ENTRIES-1, entries_in_use 256, top_count 1.
module top_k_sum_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] entry_index, [39:8] new_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [39:0] top_sum
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tkst_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEL  = 3'd1;
  localparam logic [2:0] ST_INS  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic REG_ENTRIES = 1'b0;
  localparam logic REG_TOP     = 1'b1;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [CFG_W-1:0]       cfg_entries;
  logic [CFG_W-1:0]       cfg_top;
  logic [CMP_W-1:0]       neff;
  logic [IDX_W-1:0]       idx_r;
  logic [VALUE_BITS-1:0]  val_r;
  logic [IDX_W-1:0]       sweep;
  logic                   sweep_last;
  logic                   in_accept;
  logic                   in_range;
  logic                   out_load;
  logic [1:0]             cmd;
  logic [SUM_BITS-1:0]    sum;
  cell_t                  insert_item;
  cell_t                  cells [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] del_le;
  logic [MAX_ENTRIES-1:0] ge;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_entries <= CFG_W'(256);
      cfg_top     <= CFG_W'(1);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_TOP) begin
        cfg_top <= pwdata[CFG_W-1:0];
      end else begin
        cfg_entries <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ENTRIES) ? {{(32-CFG_W){1'b0}}, cfg_entries}
                                            : {{(32-CFG_W){1'b0}}, cfg_top};

  always_comb begin
    if (cfg_entries == '0) begin
      neff = CMP_W'(1);
    end else if (32'(cfg_entries) > MAX_ENTRIES) begin
      neff = CMP_W'(MAX_ENTRIES);
    end else begin
      neff = CMP_W'(cfg_entries);
    end
  end

  // control
  assign s_tready   = (state == ST_IDLE);
  assign in_accept  = s_tvalid && s_tready;
  assign in_range   = 32'(s_tdata[INDEX_BITS-1:0]) < MAX_ENTRIES;
  assign sweep_last = (sweep == IDX_W'(MAX_ENTRIES - 1));
  assign out_load   = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_accept) state_next = in_range ? ST_DEL : ST_SUM;
      ST_DEL:  state_next = ST_INS;
      ST_INS:  state_next = ST_SUM;
      ST_SUM:  if (sweep_last) state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sweep    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      sweep <= (state == ST_SUM) ? sweep + IDX_W'(1) : '0;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      idx_r <= IDX_W'(s_tdata[INDEX_BITS-1:0]);
      val_r <= VALUE_BITS'(s_tdata[INDEX_BITS +: DATA_BITS]);
    end
    if (out_load) begin
      m_tdata <= sum;
    end
  end

  always_comb begin
    unique case (state)
      ST_DEL:  cmd = CMD_DEL;
      ST_INS:  cmd = CMD_INS;
      ST_SUM:  cmd = CMD_ROT;
      default: cmd = CMD_HOLD;
    endcase
  end

  assign insert_item.tag   = idx_r;
  assign insert_item.value = val_r;
  assign del_le            = prefix_or(match);

  // cell chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    cell_ctl_t ctl;

    assign match[i] = (cells[i].tag == idx_r);
    // after removal the last cell holds no entry
    assign ge[i]    = (i == MAX_ENTRIES - 1) ? 1'b0 : (cells[i].value >= val_r);

    always_comb begin
      ctl.cmd        = cmd;
      ctl.take_right = del_le[i];
      ctl.ge_self    = ge[i];
      ctl.ge_left    = (i == 0) ? 1'b1 : ge[(i + MAX_ENTRIES - 1) % MAX_ENTRIES];
    end

    tkst_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .reset_tag   (IDX_W'(i)),
      .ctl         (ctl),
      .left        (cells[(i + MAX_ENTRIES - 1) % MAX_ENTRIES]),
      .right       (cells[(i + 1) % MAX_ENTRIES]),
      .insert_item (insert_item),
      .data        (cells[i])
    );
  end

  tkst_accum u_accum (
    .clk   (clk),
    .rst   (rst),
    .clear (in_accept),
    .en    (state == ST_SUM),
    .head  (cells[0]),
    .neff  (neff),
    .k     (CMP_W'(cfg_top)),
    .sum   (sum)
  );

endmodule

[test/testbench.sv]
// Testbench for top_k_sum_tracker: directed and random updates checked against a top-k sum model.
`timescale 1ns / 100ps

module testbench;
  import tkst_pkg::*;

  localparam logic [2:0] REG_ENTRIES_IN_USE = 3'd0;
  localparam logic [2:0] REG_TOP_COUNT      = 3'd4;
  localparam int ITEM_TARGET = 850;
  localparam int TAIL_ITEMS  = 100;
  localparam int STALL_LIMIT = 5000;
  localparam int PRINT_CAP   = 200;

  typedef struct packed {
    logic                cfg;
    logic [8:0]          n;
    logic [8:0]          k;
    logic [7:0]          idx;
    logic [31:0]         val;
    logic                known;
    logic [SUM_BITS-1:0] sum;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // [7:0] entry_index, [39:8] new_value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;       // [39:0] top_sum
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  top_k_sum_tracker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  logic [31:0]         entry_mirror [MAX_ENTRIES];
  logic [8:0]          cfg_n = 9'd256;
  logic [8:0]          cfg_k = 9'd1;
  logic [SUM_BITS-1:0] pending_sums [$];
  logic                typed_known = 1'b0;
  logic [SUM_BITS-1:0] typed_sum = '0;
  int                  errors = 0;
  int                  sent = 0;
  int                  idle_cycles = 0;
  int                  rx_hold = 0;
  bit                  rx_calm = 1'b0;
  bit                  tx_bursty = 1'b1;
  bit                  tail_quiet = 1'b0;

  stim_row_t directed_rows [17] = '{
    '{1'b0, 9'd0,   9'd0,   8'd0,   32'h0000_0000, 1'b1, 40'h00_0000_0000},
    '{1'b0, 9'd0,   9'd0,   8'd0,   32'hFFFF_FFFF, 1'b1, 40'h00_FFFF_FFFF},
    '{1'b0, 9'd0,   9'd0,   8'd255, 32'hFFFF_FFFF, 1'b1, 40'h00_FFFF_FFFF},
    '{1'b1, 9'd256, 9'd256, 8'd128, 32'hFFFF_FFFF, 1'b1, 40'h02_FFFF_FFFD},
    '{1'b0, 9'd0,   9'd0,   8'd255, 32'h0000_0000, 1'b1, 40'h01_FFFF_FFFE},
    // zero entries counts as one, oversized top count clamps
    '{1'b1, 9'd0,   9'd511, 8'd5,   32'h0000_0007, 1'b1, 40'h00_FFFF_FFFF},
    '{1'b0, 9'd0,   9'd0,   8'd0,   32'h0000_0001, 1'b1, 40'h00_0000_0001},
    // zero top count
    '{1'b1, 9'd511, 9'd0,   8'd3,   32'h0000_0009, 1'b1, 40'h00_0000_0000},
    // write outside the entries in use
    '{1'b1, 9'd4,   9'd2,   8'd200, 32'h0000_0064, 1'b1, 40'h00_0000_000A},
    '{1'b0, 9'd0,   9'd0,   8'd1,   32'h0000_0009, 1'b1, 40'h00_0000_0012},
    '{1'b0, 9'd0,   9'd0,   8'd2,   32'h0000_0009, 1'b1, 40'h00_0000_0012},
    '{1'b1, 9'd201, 9'd3,   8'd4,   32'h8000_0000, 1'b0, 40'h0},
    '{1'b0, 9'd0,   9'd0,   8'd0,   32'h5555_5555, 1'b0, 40'h0},
    '{1'b0, 9'd0,   9'd0,   8'd1,   32'hAAAA_AAAA, 1'b0, 40'h0},
    '{1'b1, 9'd256, 9'd255, 8'd17,  32'h1234_5678, 1'b0, 40'h0},
    '{1'b1, 9'd2,   9'd2,   8'd1,   32'hFFFF_FFFF, 1'b0, 40'h0},
    '{1'b1, 9'd256, 9'd256, 8'd255, 32'hFFFF_FFFF, 1'b0, 40'h0}
  };

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int clamp_entries(input logic [8:0] n);
    if (n == 0) return 1;
    if (n > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(n);
  endfunction

  function automatic logic [SUM_BITS-1:0] top_sum_now();
    logic [31:0]         ranked [MAX_ENTRIES];
    logic [31:0]         v;
    logic [SUM_BITS-1:0] total;
    int                  n;
    int                  k;
    int                  j;
    n = clamp_entries(cfg_n);
    k = (int'(cfg_k) > n) ? n : int'(cfg_k);
    for (int i = 0; i < n; i++) begin
      v = entry_mirror[i];
      j = i;
      while (j > 0 && ranked[j-1] < v) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = v;
    end
    total = '0;
    for (int i = 0; i < k; i++) total = total + {8'd0, ranked[i]};
    return total;
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    if (errors < PRINT_CAP)
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // beat monitor, predictor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        entry_mirror[s_tdata[7:0]] = s_tdata[39:8];
        if (typed_known) pending_sums.push_back(typed_sum);
        else pending_sums.push_back(top_sum_now());
      end
      if (m_tvalid && m_tready) begin
        if (pending_sums.size() == 0) report_mismatch("unexpected top_sum", m_tdata, '0);
        else if (m_tdata !== pending_sums[0])
          report_mismatch("top_sum", m_tdata, pending_sums.pop_front());
        else void'(pending_sums.pop_front());
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (rx_hold != 0) rx_hold--;
    else if (!tail_quiet && !rx_calm && $urandom_range(0, 5) == 0)
      rx_hold = $urandom_range(1, 13);
    if ($urandom_range(0, 399) == 0) rx_calm = !rx_calm;
    m_tready <= (rx_hold == 0);
  end

  task automatic write_reg(input logic [2:0] addr, input logic [8:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= {23'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == REG_ENTRIES_IN_USE) cfg_n = value;
    else cfg_k = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic read_reg(input logic [2:0] addr, input logic [8:0] want);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {23'd0, want}) report_mismatch("register readback", 40'(prdata), 40'(want));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [8:0] n, input logic [8:0] k);
    drain_results();
    write_reg(REG_ENTRIES_IN_USE, n);
    write_reg(REG_TOP_COUNT, k);
    read_reg(REG_ENTRIES_IN_USE, n);
    read_reg(REG_TOP_COUNT, k);
  endtask

  task automatic send_update(input logic [7:0] idx, input logic [31:0] val, input logic known,
                             input logic [SUM_BITS-1:0] sum);
    int gap;
    gap = 0;
    if (!tail_quiet && tx_bursty && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 13);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {val, idx};
    typed_known = known;
    typed_sum = sum;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  function automatic logic [8:0] pick_entries();
    case ($urandom_range(0, 7))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd2;
      3: return 9'd256;
      4: return 9'd511;
      5: return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(1, 256));
    endcase
  endfunction

  function automatic logic [8:0] pick_top(input logic [8:0] n);
    int eff;
    eff = clamp_entries(n);
    case ($urandom_range(0, 6))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'(eff);
      3: return 9'd511;
      4: return 9'($urandom_range(eff, 511));
      default: return 9'($urandom_range(1, eff));
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 3);
      3: return 32'h8000_0000 | $urandom_range(0, 7);
      4: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [8:0] n;
    logic [8:0] k;
    int         start;
    int         phase_len;

    for (int i = 0; i < MAX_ENTRIES; i++) entry_mirror[i] = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    read_reg(REG_ENTRIES_IN_USE, 9'd256);
    read_reg(REG_TOP_COUNT, 9'd1);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg) configure(directed_rows[i].n, directed_rows[i].k);
      send_update(directed_rows[i].idx, directed_rows[i].val, directed_rows[i].known,
                  directed_rows[i].sum);
    end

    // sweep every entry to the maximum so the sum reaches its top
    configure(9'd256, 9'd256);
    start = $urandom_range(0, 255);
    for (int i = 0; i < MAX_ENTRIES; i++)
      send_update(8'(start + i), 32'hFFFF_FFFF, 1'b0, '0);

    while (sent < ITEM_TARGET) begin
      phase_len = $urandom_range(15, 70);
      n = pick_entries();
      k = pick_top(n);
      tx_bursty = ($urandom_range(0, 3) != 0);
      configure(n, k);
      repeat (phase_len) begin
        if (sent >= ITEM_TARGET) break;
        tail_quiet = (sent >= ITEM_TARGET - TAIL_ITEMS);
        if ($urandom_range(0, 49) == 0) drain_results();
        if ($urandom_range(0, 3) == 0)
          send_update(8'($urandom_range(0, 255)), pick_value(), 1'b0, '0);
        else
          send_update(8'($urandom_range(0, clamp_entries(n) - 1)), pick_value(), 1'b0, '0);
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    drain_results();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_sums.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
